[hw/rtl/mrp_pkg.sv]
`timescale 1ns / 1ps

package mrp_pkg;

    localparam int LEN_W       = 28;
    localparam int TOPIC_W     = 16;
    localparam int MAX_RESULTS = 5;
    localparam int COUNT_W     = 3;

    localparam logic [LEN_W-1:0] MAX_BODY_RESET = 28'd4194304;

    localparam logic [2:0] KIND_TOPIC   = 3'd0;
    localparam logic [2:0] KIND_PAYLOAD = 3'd1;
    localparam logic [2:0] KIND_PUBACK  = 3'd2;
    localparam logic [2:0] KIND_DONE    = 3'd3;
    localparam logic [2:0] KIND_ERROR   = 3'd4;

    localparam logic [3:0] TYPE_PUBLISH  = 4'd3;
    localparam logic [7:0] PUBACK_HEADER = 8'h40;
    localparam logic [7:0] PUBACK_LENGTH = 8'h02;

    typedef enum logic [8:0] {
        PH_HEADER  = 9'b000000001,
        PH_LENGTH  = 9'b000000010,
        PH_TLEN_HI = 9'b000000100,
        PH_TLEN_LO = 9'b000001000,
        PH_TOPIC   = 9'b000010000,
        PH_PID_HI  = 9'b000100000,
        PH_PID_LO  = 9'b001000000,
        PH_PAYLOAD = 9'b010000000,
        PH_SKIP    = 9'b100000000
    } phase_t;

    // All results caused by one received byte, in delivery order.
    typedef struct packed {
        logic [COUNT_W-1:0]               count;
        logic [MAX_RESULTS-1:0][2:0]      kind;
        logic [MAX_RESULTS-1:0][7:0]      data;
    } result_group_t;

endpackage

[hw/rtl/mqtt_receive_parser.sv]
`timescale 1ns / 1ps
// The first result of a byte is registered and appears in the cycle after the byte is accepted.
// Throughput: one byte per cycle while each byte yields at most one result and out_ready
// is high; a byte that yields n results (up to five: a PUBACK plus message done) holds input
// until the single-entry output port has drained the result queue down to its final entry.
// Reset (rst_n, asynchronous, active low) returns to waiting for a fixed header.

module mqtt_receive_parser
    import mrp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        rx_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        result_kind,
    output logic [7:0]        data,
    output logic              last,
    input  logic              cfg_write_en,
    input  logic [LEN_W-1:0]  cfg_write_data
);

    result_group_t group;
    logic          accept;

    assign accept = in_valid && in_ready;

    mrp_parse u_parse (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .rx_byte        (rx_byte),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .group          (group)
    );

    mrp_outq u_outq (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (accept),
        .group       (group),
        .can_load    (in_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_kind (result_kind),
        .data        (data),
        .last        (last)
    );

endmodule

[hw/rtl/mrp_parse.sv]
`timescale 1ns / 1ps

module mrp_parse
    import mrp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           rx_byte,
    input  logic                 cfg_write_en,
    input  logic [LEN_W-1:0]     cfg_write_data,
    output result_group_t        group
);

    phase_t               phase_reg, phase_next;
    logic [1:0]           qos_reg, qos_next;
    logic                 is_publish_reg, is_publish_next;
    logic [LEN_W-1:0]     length_accum_reg, length_accum_next;
    logic [2:0]           length_count_reg, length_count_next;
    logic [LEN_W-1:0]     body_left_reg, body_left_next;
    logic [TOPIC_W-1:0]   topic_left_reg, topic_left_next;
    logic [7:0]           pid_high_reg, pid_high_next;
    logic                 stream_dead_reg, stream_dead_next;
    logic [LEN_W-1:0]     max_body_reg;

    always_comb
    begin
        logic [LEN_W-1:0]   bl;
        logic [LEN_W-1:0]   add;
        logic [LEN_W-1:0]   acc;
        logic [TOPIC_W-1:0] t;
        logic [2:0]         cnt_n;
        logic [COUNT_W-1:0] n;
        logic               done;
        logic               topic_end;

        phase_next        = phase_reg;
        qos_next          = qos_reg;
        is_publish_next   = is_publish_reg;
        length_accum_next = length_accum_reg;
        length_count_next = length_count_reg;
        body_left_next    = body_left_reg;
        topic_left_next   = topic_left_reg;
        pid_high_next     = pid_high_reg;
        stream_dead_next  = stream_dead_reg;
        group             = '0;
        n                 = '0;
        done              = 1'b0;
        topic_end         = 1'b0;
        add               = '0;
        acc               = '0;
        t                 = '0;
        cnt_n             = '0;
        bl                = body_left_reg;

        if (!stream_dead_reg)
        begin
            // The body counter runs down on every body byte.
            if (phase_reg != PH_HEADER && phase_reg != PH_LENGTH && body_left_reg != '0)
            begin
                bl = body_left_reg - LEN_W'(1);
            end
            body_left_next = bl;

            case (phase_reg)
                PH_LENGTH:
                begin
                    case (length_count_reg[1:0])
                        2'd0:    add = {21'd0, rx_byte[6:0]};
                        2'd1:    add = {14'd0, rx_byte[6:0], 7'd0};
                        2'd2:    add = {7'd0, rx_byte[6:0], 14'd0};
                        default: add = {rx_byte[6:0], 21'd0};
                    endcase
                    acc               = length_accum_reg + add;
                    cnt_n             = length_count_reg + 3'd1;
                    length_accum_next = acc;
                    length_count_next = cnt_n;
                    if (!rx_byte[7] || cnt_n >= 3'd4)
                    begin
                        if (acc > max_body_reg)
                        begin
                            stream_dead_next = 1'b1;
                            group.kind[0]    = KIND_ERROR;
                            n                = COUNT_W'(1);
                        end
                        else if (acc == '0)
                        begin
                            phase_next = PH_HEADER;
                        end
                        else
                        begin
                            body_left_next = acc;
                            if (is_publish_reg && acc >= LEN_W'(2))
                                phase_next = PH_TLEN_HI;
                            else
                                phase_next = PH_SKIP;
                        end
                    end
                end
                PH_TLEN_HI:
                begin
                    topic_left_next = {rx_byte, 8'd0};
                    phase_next      = PH_TLEN_LO;
                end
                PH_TLEN_LO:
                begin
                    t               = topic_left_reg | {8'd0, rx_byte};
                    topic_left_next = t;
                    if (bl < {12'd0, t})
                        phase_next = (bl == '0) ? PH_HEADER : PH_SKIP;
                    else if (t != '0)
                        phase_next = PH_TOPIC;
                    else
                        topic_end = 1'b1;
                end
                PH_TOPIC:
                begin
                    group.kind[0]   = KIND_TOPIC;
                    group.data[0]   = rx_byte;
                    n               = COUNT_W'(1);
                    t               = topic_left_reg - TOPIC_W'(1);
                    topic_left_next = t;
                    if (t == '0)
                        topic_end = 1'b1;
                end
                PH_PID_HI:
                begin
                    pid_high_next = rx_byte;
                    if (bl == '0)
                        done = 1'b1;
                    else
                        phase_next = PH_PID_LO;
                end
                PH_PID_LO:
                begin
                    if (qos_reg == 2'd1)
                    begin
                        group.kind[0] = KIND_PUBACK;
                        group.data[0] = PUBACK_HEADER;
                        group.kind[1] = KIND_PUBACK;
                        group.data[1] = PUBACK_LENGTH;
                        group.kind[2] = KIND_PUBACK;
                        group.data[2] = pid_high_reg;
                        group.kind[3] = KIND_PUBACK;
                        group.data[3] = rx_byte;
                        n             = COUNT_W'(4);
                    end
                    if (bl == '0)
                        done = 1'b1;
                    else
                        phase_next = PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    group.kind[0] = KIND_PAYLOAD;
                    group.data[0] = rx_byte;
                    n             = COUNT_W'(1);
                    if (bl == '0)
                        done = 1'b1;
                end
                PH_SKIP:
                begin
                    if (bl == '0)
                        phase_next = PH_HEADER;
                end
                default:
                begin
                    is_publish_next   = (rx_byte[7:4] == TYPE_PUBLISH);
                    qos_next          = rx_byte[2:1];
                    length_accum_next = '0;
                    length_count_next = '0;
                    phase_next        = PH_LENGTH;
                end
            endcase

            // Topic complete: finish, read the packet id, or go to the payload.
            if (topic_end)
            begin
                if (bl == '0)
                    done = 1'b1;
                else if (qos_reg != 2'd0)
                    phase_next = PH_PID_HI;
                else
                    phase_next = PH_PAYLOAD;
            end

            if (done)
            begin
                group.kind[n] = KIND_DONE;
                group.data[n] = 8'd0;
                n             = n + COUNT_W'(1);
                phase_next    = PH_HEADER;
            end
        end

        group.count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HEADER;
            qos_reg          <= '0;
            is_publish_reg   <= 1'b0;
            length_accum_reg <= '0;
            length_count_reg <= '0;
            body_left_reg    <= '0;
            topic_left_reg   <= '0;
            pid_high_reg     <= '0;
            stream_dead_reg  <= 1'b0;
            max_body_reg     <= MAX_BODY_RESET;
        end
        else
        begin
            if (accept)
            begin
                phase_reg        <= phase_next;
                qos_reg          <= qos_next;
                is_publish_reg   <= is_publish_next;
                length_accum_reg <= length_accum_next;
                length_count_reg <= length_count_next;
                body_left_reg    <= body_left_next;
                topic_left_reg   <= topic_left_next;
                pid_high_reg     <= pid_high_next;
                stream_dead_reg  <= stream_dead_next;
            end
            if (cfg_write_en)
            begin
                max_body_reg <= cfg_write_data;
            end
        end
    end

    a_dead_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        stream_dead_reg |=> stream_dead_reg)
        else $error("stream error state was left without reset");

    a_dead_silent: assert property (@(posedge clk) disable iff (!rst_n)
        stream_dead_reg |-> group.count == '0)
        else $error("results produced after a stream error");

    a_length_count: assert property (@(posedge clk) disable iff (!rst_n)
        length_count_reg <= 3'd4)
        else $error("remaining length ran past four bytes");

endmodule

[hw/rtl/mrp_outq.sv]
`timescale 1ns / 1ps

module mrp_outq
    import mrp_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  result_group_t  group,
    output logic           can_load,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [2:0]     result_kind,
    output logic [7:0]     data,
    output logic           last
);

    logic [COUNT_W-1:0]          count_reg;
    logic [MAX_RESULTS-1:0][2:0] kind_reg;
    logic [MAX_RESULTS-1:0][7:0] data_reg;
    logic                        pop;

    assign out_valid   = (count_reg != '0);
    assign pop         = out_valid && out_ready;
    assign result_kind = kind_reg[0];
    assign data        = data_reg[0];
    assign last        = (count_reg == COUNT_W'(1));
    // A new request may enter when the queue is empty or its final entry leaves now.
    assign can_load    = (count_reg == '0) || (last && out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (load)
        begin
            count_reg <= group.count;
        end
        else if (pop)
        begin
            count_reg <= count_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= group.kind;
            data_reg <= group.data;
        end
        else if (pop)
        begin
            for (int i = 0; i < MAX_RESULTS - 1; i++)
            begin
                kind_reg[i] <= kind_reg[i + 1];
                data_reg[i] <= data_reg[i + 1];
            end
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(MAX_RESULTS))
        else $error("result queue holds more than a full group");

    a_pop_step: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !load) |=> count_reg == $past(count_reg) - COUNT_W'(1))
        else $error("result queue count did not step down on a pop");

    a_load_empty: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (count_reg == '0) || (count_reg == COUNT_W'(1) && pop))
        else $error("group loaded over pending results");

endmodule

[test/mqtt_receive_parser_checker.sv]
`timescale 1ns / 1ps

module mqtt_receive_parser_checker
    import mrp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [7:0]        rx_byte,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [2:0]        result_kind,
    input  logic [7:0]        data,
    input  logic              last,
    input  logic              cfg_write_en,
    input  logic [LEN_W-1:0]  cfg_write_data,
    output int                fail_count,
    output int                pending
);

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic       last;
    } parser_result_t;

    parser_result_t expected_q[$];
    int mismatches = 0;
    int waiting = 0;

    assign fail_count = mismatches;
    assign pending    = waiting;

    // Mirror of the parser state.
    logic [LEN_W-1:0]   body_limit;
    phase_t             parse_phase;
    logic [1:0]         hdr_qos;
    logic               publish_hdr;
    logic [LEN_W-1:0]   len_accum;
    logic [2:0]         len_bytes;
    logic [LEN_W-1:0]   body_remaining;
    logic [TOPIC_W-1:0] topic_remaining;
    logic [7:0]         pid_high;
    logic               dead;

    // Results caused by the byte being parsed.
    logic [2:0] byte_kind [MAX_RESULTS];
    logic [7:0] byte_data [MAX_RESULTS];
    int         byte_count;

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("%0t ns: mismatch on %s: expected %0h, got %0h", $time, what, want, got);
        mismatches++;
    endtask

    task automatic emit(input logic [2:0] kind, input logic [7:0] value);
        byte_kind[byte_count] = kind;
        byte_data[byte_count] = value;
        byte_count++;
    endtask

    task automatic finish_message();
        emit(KIND_DONE, 8'h00);
        parse_phase = PH_HEADER;
    endtask

    task automatic topic_complete();
        if (body_remaining == 0)
            finish_message();
        else if (hdr_qos != 0)
            parse_phase = PH_PID_HI;
        else
            parse_phase = PH_PAYLOAD;
    endtask

    task automatic parse_byte(input logic [7:0] b);
        byte_count = 0;
        if (dead)
            return;

        // The body counter runs down on every byte once the length is known.
        if (parse_phase != PH_HEADER && parse_phase != PH_LENGTH && body_remaining != 0)
            body_remaining = body_remaining - 1'b1;

        case (parse_phase)
            PH_LENGTH:
            begin
                len_accum = len_accum + ({21'd0, b[6:0]} << (7 * len_bytes[1:0]));
                len_bytes = len_bytes + 1'b1;
                if (!b[7] || len_bytes >= 4)
                begin
                    if (len_accum > body_limit)
                    begin
                        dead = 1'b1;
                        emit(KIND_ERROR, 8'h00);
                    end
                    else if (len_accum == 0)
                        parse_phase = PH_HEADER;
                    else
                    begin
                        body_remaining = len_accum;
                        if (publish_hdr && len_accum >= 2)
                            parse_phase = PH_TLEN_HI;
                        else
                            parse_phase = PH_SKIP;
                    end
                end
            end
            PH_TLEN_HI:
            begin
                topic_remaining = {b, 8'h00};
                parse_phase = PH_TLEN_LO;
            end
            PH_TLEN_LO:
            begin
                topic_remaining = {topic_remaining[15:8], b};
                if (body_remaining < topic_remaining)
                    parse_phase = (body_remaining == 0) ? PH_HEADER : PH_SKIP;
                else if (topic_remaining != 0)
                    parse_phase = PH_TOPIC;
                else
                    topic_complete();
            end
            PH_TOPIC:
            begin
                emit(KIND_TOPIC, b);
                topic_remaining = topic_remaining - 1'b1;
                if (topic_remaining == 0)
                    topic_complete();
            end
            PH_PID_HI:
            begin
                pid_high = b;
                if (body_remaining == 0)
                    finish_message();
                else
                    parse_phase = PH_PID_LO;
            end
            PH_PID_LO:
            begin
                // Only QoS 1 is acknowledged; QoS 2 and 3 just drop the id.
                if (hdr_qos == 2'd1)
                begin
                    emit(KIND_PUBACK, PUBACK_HEADER);
                    emit(KIND_PUBACK, PUBACK_LENGTH);
                    emit(KIND_PUBACK, pid_high);
                    emit(KIND_PUBACK, b);
                end
                if (body_remaining == 0)
                    finish_message();
                else
                    parse_phase = PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                emit(KIND_PAYLOAD, b);
                if (body_remaining == 0)
                    finish_message();
            end
            PH_SKIP:
            begin
                if (body_remaining == 0)
                    parse_phase = PH_HEADER;
            end
            default:
            begin
                publish_hdr = (b[7:4] == TYPE_PUBLISH);
                hdr_qos     = b[2:1];
                len_accum   = '0;
                len_bytes   = '0;
                parse_phase = PH_LENGTH;
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        parser_result_t exp;
        int i;
        if (!rst_n)
        begin
            body_limit      = MAX_BODY_RESET;
            parse_phase     = PH_HEADER;
            hdr_qos         = '0;
            publish_hdr     = 1'b0;
            len_accum       = '0;
            len_bytes       = '0;
            body_remaining  = '0;
            topic_remaining = '0;
            pid_high        = '0;
            dead            = 1'b0;
            expected_q.delete();
            waiting         = 0;
        end
        else
        begin
            if (cfg_write_en)
                body_limit = cfg_write_data;

            if (in_valid && in_ready)
            begin
                parse_byte(rx_byte);
                for (i = 0; i < byte_count; i++)
                begin
                    exp.kind = byte_kind[i];
                    exp.data = byte_data[i];
                    exp.last = (i == byte_count - 1);
                    expected_q = {expected_q, exp};
                end
            end

            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                    report_mismatch("unexpected result kind", -1, int'(result_kind));
                else
                begin
                    exp = expected_q.pop_front();
                    if (result_kind !== exp.kind)
                        report_mismatch("result_kind", int'(exp.kind), int'(result_kind));
                    if (data !== exp.data)
                        report_mismatch("data", int'(exp.data), int'(data));
                    if (last !== exp.last)
                        report_mismatch("last", int'(exp.last), int'(last));
                end
            end

            waiting = expected_q.size();
        end
    end

endmodule

[test/tb_mqtt_receive_parser.sv]
`timescale 1ns / 1ps

module tb_mqtt_receive_parser;
    import mrp_pkg::*;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic [7:0]       rx_byte;
    logic             out_valid;
    logic             out_ready;
    logic [2:0]       result_kind;
    logic [7:0]       data;
    logic             last;
    logic             cfg_write_en;
    logic [LEN_W-1:0] cfg_write_data;
    int               fail_count;
    int               pending;

    logic [7:0] tx_bytes[$];
    int         in_burst;
    int         out_burst;

    mqtt_receive_parser u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_kind    (result_kind),
        .data           (data),
        .last           (last),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    mqtt_receive_parser_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_kind    (result_kind),
        .data           (data),
        .last           (last),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("[mqtt_receive_parser] ERROR");
        $finish;
    end

    // Mostly random waits, with occasional stretches of back-to-back requests.
    task automatic draw_wait(inout int burst, output int cycles);
        if (burst > 0)
        begin
            burst--;
            cycles = 0;
        end
        else
        begin
            if ($urandom_range(0, 15) == 0)
                burst = $urandom_range(8, 40);
            cycles = $urandom_range(0, 19);
        end
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic push_byte(input logic [7:0] b);
        int gap;
        draw_wait(in_burst, gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            rx_byte  <= 8'($urandom_range(0, 255));
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_queued();
        while (tx_bytes.size() != 0)
            push_byte(tx_bytes.pop_front());
    endtask

    // Drop valid and let every outstanding result drain.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic set_body_limit(input logic [LEN_W-1:0] value);
        drain();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(negedge clk);
        cfg_write_en   <= 1'b0;
    endtask

    // Remaining length, low group first; padding adds redundant zero groups.
    task automatic put_length(input int len, input bit pad);
        logic [7:0] grp[4];
        int n;
        int target;
        int i;
        bit hang;
        n = 0;
        do
        begin
            grp[n] = 8'(len % 128);
            len = len / 128;
            n++;
        end
        while (len != 0);
        target = (pad && n < 4) ? $urandom_range(n + 1, 4) : n;
        for (i = n; i < target; i++)
            grp[i] = 8'h00;
        // A fourth group ends the field even with its continuation bit set.
        hang = pad && target == 4 && $urandom_range(0, 1);
        for (i = 0; i < target; i++)
            tx_bytes = {tx_bytes, grp[i] | ((i < target - 1 || hang) ? 8'h80 : 8'h00)};
    endtask

    task automatic put_publish(input int qos, input int name_len, input int payload_len,
                               input int cut, input bit bad_topic, input int limit);
        logic [7:0] body[$];
        int topic_field;
        int declared;
        int i;
        logic dup;
        logic retain;
        dup    = 1'($urandom_range(0, 1));
        retain = 1'($urandom_range(0, 1));
        topic_field = bad_topic ? $urandom_range(0, 65535) : name_len;
        body = {body, topic_field[15:8]};
        body = {body, topic_field[7:0]};
        for (i = 0; i < name_len; i++)
            body = {body, 8'($urandom_range(0, 255))};
        if (qos != 0)
        begin
            body = {body, 8'($urandom_range(0, 255))};
            body = {body, 8'($urandom_range(0, 255))};
        end
        for (i = 0; i < payload_len; i++)
            body = {body, 8'($urandom_range(0, 255))};
        declared = body.size() - cut;
        if (declared < 0)
            declared = 0;
        if (declared > limit)
            declared = limit;
        tx_bytes = {tx_bytes, {TYPE_PUBLISH, dup, qos[1:0], retain}};
        put_length(declared, $urandom_range(0, 7) == 0);
        for (i = 0; i < declared; i++)
            tx_bytes = {tx_bytes, body[i]};
    endtask

    task automatic put_other(input int body_len, input int limit);
        int kind_code;
        int i;
        kind_code = $urandom_range(0, 14);
        if (kind_code >= TYPE_PUBLISH)
            kind_code++;
        if (body_len > limit)
            body_len = limit;
        tx_bytes = {tx_bytes, {kind_code[3:0], 4'($urandom_range(0, 15))}};
        put_length(body_len, $urandom_range(0, 3) == 0);
        for (i = 0; i < body_len; i++)
            tx_bytes = {tx_bytes, 8'($urandom_range(0, 255))};
    endtask

    task automatic put_random_packet(input int limit);
        int pick;
        int name_len;
        int payload_len;
        pick = $urandom_range(0, 99);
        name_len = $urandom_range(0, 6);
        payload_len = ($urandom_range(0, 19) == 0) ? $urandom_range(120, 200)
                                                    : $urandom_range(0, 12);
        if (pick < 62)
            put_publish($urandom_range(0, 3), name_len, payload_len, 0, 1'b0, limit);
        else if (pick < 72)
            // Truncated body: short body, cut topic, or missing packet id.
            put_publish($urandom_range(0, 3), name_len, $urandom_range(0, 3),
                        $urandom_range(1, name_len + 7), 1'b0, limit);
        else if (pick < 78)
            put_publish($urandom_range(0, 3), name_len, payload_len, 0, 1'b1, limit);
        else if (pick < 94)
            put_other($urandom_range(0, 8), limit);
        else
            put_other(0, limit);
    endtask

    task automatic run_random(input int nbytes, input int limit);
        while (tx_bytes.size() < nbytes)
            put_random_packet(limit);
        send_queued();
    endtask

    initial
    begin : out_side
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            draw_wait(out_burst, stall);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!(out_valid && out_ready))
                @(posedge clk);
            @(negedge clk);
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        rx_byte        = 8'h00;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        in_burst       = 0;
        out_burst      = 0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty body, then a four-group length of zero.
        tx_bytes = '{8'hC0, 8'h00, 8'hE0, 8'h80, 8'h80, 8'h80, 8'h80};
        // QoS 1 with a one-byte topic, packet id and extreme payload bytes.
        tx_bytes = {tx_bytes, 8'h32, 8'h07, 8'h00, 8'h01, 8'h61, 8'h12, 8'h34,
                    8'hFF, 8'h00};
        // Body too short for a topic length.
        tx_bytes = {tx_bytes, 8'h30, 8'h01, 8'h00};
        // QoS 2 whose body ends inside the packet id.
        tx_bytes = {tx_bytes, 8'h34, 8'h03, 8'h00, 8'h00, 8'h55};
        send_queued();

        run_random(130, int'(MAX_BODY_RESET));

        set_body_limit(28'hFFFFFFF);
        run_random(130, 28'hFFFFFFF);

        set_body_limit(28'd40);
        run_random(130, 40);
        put_publish(1, 3, 33, 0, 1'b0, 40);
        send_queued();

        // With no body allowed, only an empty packet passes; the next length kills
        // the stream and the bytes after it must produce nothing.
        set_body_limit('0);
        tx_bytes = '{8'hD0, 8'h00, 8'h30, 8'hFF, 8'hFF, 8'hFF, 8'h7F};
        repeat (6) tx_bytes = {tx_bytes, 8'($urandom_range(0, 255))};
        send_queued();

        drain();
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("[mqtt_receive_parser] OK");
        else
            $display("[mqtt_receive_parser] ERROR");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/mrp_pkg.sv
hw/rtl/mrp_parse.sv
hw/rtl/mrp_outq.sv
hw/rtl/mqtt_receive_parser.sv
test/mqtt_receive_parser_checker.sv
test/tb_mqtt_receive_parser.sv
